// ===== rtl/dis_pkg.sv =====
// Package for the disjoint interval set: request codes, status codes, beat structs.
// No dependencies.
`timescale 1ns / 1ps
package dis_pkg;
    localparam int DefCapacity = 64;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_SAME   = 3'd3;
    localparam logic [2:0] REQ_MEX    = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               hit;
        logic signed [31:0] found_lo;
        logic signed [31:0] found_hi;
        logic               same_flag;
        logic [31:0]        mex_value;
    } t_rsp;
endpackage

// ===== rtl/dis_mem.sv =====
// Interval memory: one write port, one registered read port, each entry is {start, end}.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module dis_mem #(
    parameter int Depth = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [63:0]       i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [63:0]       o_rdata
);
    logic [63:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/disjoint_interval_set.sv =====
// Disjoint interval set: sequencer over one interval memory and one shared compare unit.
// Depends on dis_pkg and dis_mem.
// Each scanned entry passes through S_SCAN_RD and S_SCAN, each moved entry through S_MV_RD
// and S_MV_WR. busy holds for the whole beat, so a new request is taken only after the last.
// Reset empties the table, sets merging of touching spans and idles the FSM; the receiver
// cannot stall.
`timescale 1ns / 1ps
module disjoint_interval_set
    import dis_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output logic o_valid,
    output t_rsp o_rsp
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_CHECK, S_MV_RD, S_MV_WR, S_WR0, S_WR1, S_DONE
    } t_state;

    t_state              r_state;
    logic                r_merge;
    logic [CW-1:0]       r_count;
    t_req                r_req;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_i, r_j;
    logic                r_i_set;
    logic signed [32:0]  r_tl, r_tr;
    logic [1:0]          r_n;
    logic signed [32:0]  r_s0, r_e0, r_s1, r_e1;
    logic [CW-1:0]       r_src, r_dst, r_newcnt;
    logic                r_up;
    t_rsp                r_rsp;
    logic                r_valid;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [63:0]         mem_wdata, mem_rdata;

    dis_mem #(.Depth(CAPACITY), .AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );

    // shared compare unit operands
    logic signed [32:0] e_s, e_e, q_lo, q_hi, m33, x_lo, x_hi;
    logic               is_upd;
    always_comb begin
        e_s  = {mem_rdata[63], mem_rdata[63:32]};
        e_e  = {mem_rdata[31], mem_rdata[31:0]};
        m33  = {32'd0, r_merge};
        x_lo = $signed({r_req.lo[31], r_req.lo});
        x_hi = $signed({r_req.hi[31], r_req.hi});
        is_upd = (r_req.req_type == REQ_INSERT);
        q_lo = x_lo - (is_upd ? m33 : 33'sd0);
        q_hi = x_hi + (is_upd ? m33 : 33'sd0);
    end

    logic [CW-1:0] scan_addr;
    always_comb begin
        mem_raddr = AW'(r_idx);
        mem_we    = 1'b0;
        mem_waddr = AW'(r_dst);
        mem_wdata = mem_rdata;
        case (r_state)
            S_MV_RD: mem_raddr = AW'(r_src);
            S_MV_WR: mem_we = 1'b1;
            S_WR0: begin
                mem_we = (r_n != 2'd0);
                mem_waddr = AW'(r_i);
                mem_wdata = {r_s0[31:0], r_e0[31:0]};
            end
            S_WR1: begin
                mem_we = (r_n == 2'd2);
                mem_waddr = AW'(r_i + CW'(1));
                mem_wdata = {r_s1[31:0], r_e1[31:0]};
            end
            default: ;
        endcase
        scan_addr = r_idx;
    end

    logic [CW+1:0] need;
    always_comb begin
        need = (CW+2)'(r_count) - (CW+2)'(r_j) + (CW+2)'(r_i) + (CW+2)'(r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_merge <= 1'b1;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == S_DONE);
            if (i_cfg_we) begin
                r_merge <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_idx   <= '0;
                        r_i_set <= 1'b0;
                        r_i     <= r_count;
                        r_j     <= r_count;
                        if ((i_req.req_type == REQ_INSERT || i_req.req_type == REQ_REMOVE)
                                && $signed(i_req.lo) > $signed(i_req.hi)) begin
                            r_rsp   <= t_rsp'({ST_BAD, 98'd0});
                            r_state <= S_DONE;
                        end else if (i_req.req_type > REQ_MEX || r_count == '0) begin
                            r_rsp   <= '0;
                            r_state <= (i_req.req_type == REQ_INSERT) ? S_DECIDE : S_DONE;
                        end else begin
                            r_rsp   <= '0;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN;
                S_SCAN: begin
                    if (r_req.req_type == REQ_INSERT || r_req.req_type == REQ_REMOVE) begin
                        if (!r_i_set && e_e >= q_lo) begin
                            r_i_set <= 1'b1;
                            r_i <= scan_addr;
                            r_tl <= e_s;
                        end
                        if (e_s > q_hi) begin
                            r_j <= scan_addr;
                            r_state <= S_DECIDE;
                        end else begin
                            r_tr <= e_e;
                            if (scan_addr + CW'(1) == r_count) begin
                                r_state <= S_DECIDE;
                            end else begin
                                r_idx <= scan_addr + CW'(1);
                                r_state <= S_SCAN_RD;
                            end
                        end
                    end else begin
                        logic signed [32:0] p;
                        p = (r_req.req_type == REQ_MEX) ? 33'sd0 : x_lo;
                        if (e_s <= p && p <= e_e) begin
                            if (r_req.req_type == REQ_LOOKUP) begin
                                r_rsp.hit <= 1'b1;
                                r_rsp.found_lo <= e_s[31:0];
                                r_rsp.found_hi <= e_e[31:0];
                            end else if (r_req.req_type == REQ_SAME) begin
                                r_rsp.same_flag <= (e_s <= x_hi) && (x_hi <= e_e);
                            end else begin
                                r_rsp.mex_value <= e_e[31:0] + 32'd1;
                            end
                            r_state <= S_DONE;
                        end else if (scan_addr + CW'(1) == r_count) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx <= scan_addr + CW'(1);
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_req.req_type == REQ_INSERT) begin
                        r_n  <= 2'd1;
                        r_s0 <= (r_i < r_j && r_tl < x_lo) ? r_tl : x_lo;
                        r_e0 <= (r_i < r_j && r_tr > x_hi) ? r_tr : x_hi;
                        r_state <= S_CHECK;
                    end else if (!(r_i < r_j)) begin
                        r_state <= S_DONE;
                    end else begin
                        logic a, b;
                        a = r_tl < x_lo;
                        b = x_hi < r_tr;
                        r_n <= {1'b0, a} + {1'b0, b};
                        if (a) begin
                            r_s0 <= r_tl;
                            r_e0 <= x_lo - 33'sd1;
                            r_s1 <= x_hi + 33'sd1;
                            r_e1 <= r_tr;
                        end else begin
                            r_s0 <= x_hi + 33'sd1;
                            r_e0 <= r_tr;
                        end
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (need > (CW+2)'(CAPACITY)) begin
                        r_rsp.status <= ST_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_newcnt <= CW'(need);
                        if (r_i + CW'(r_n) > r_j && r_j != r_count) begin
                            // shift tail up, from the top
                            r_up  <= 1'b1;
                            r_src <= r_count - CW'(1);
                            r_dst <= r_count - CW'(1) + CW'(r_n) - (r_j - r_i);
                            r_state <= S_MV_RD;
                        end else if (r_i + CW'(r_n) < r_j && r_j != r_count) begin
                            r_up  <= 1'b0;
                            r_src <= r_j;
                            r_dst <= r_i + CW'(r_n);
                            r_state <= S_MV_RD;
                        end else begin
                            r_state <= S_WR0;
                        end
                    end
                end
                S_MV_RD: r_state <= S_MV_WR;
                S_MV_WR: begin
                    if (r_up ? (r_src == r_j) : (r_src + CW'(1) == r_count)) begin
                        r_state <= S_WR0;
                    end else begin
                        r_src <= r_up ? r_src - CW'(1) : r_src + CW'(1);
                        r_dst <= r_up ? r_dst - CW'(1) : r_dst + CW'(1);
                        r_state <= S_MV_RD;
                    end
                end
                S_WR0: r_state <= S_WR1;
                S_WR1: begin
                    r_state <= S_DONE;
                    r_count <= r_newcnt;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy);
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid);
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY));
endmodule
